/* hdl/dtc_pkg.sv */
package dtc_pkg;

  localparam int AVERAGE_COUNT = 10;

  // Floor division of the sample sum by AVERAGE_COUNT through a reciprocal.
  // The sum stays below 4096, so a 16-bit fraction keeps the error under one LSB.
  localparam int SUM_W       = 12;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'((2 ** RECIP_SHIFT + AVERAGE_COUNT - 1) / AVERAGE_COUNT);
  localparam logic [3:0] AVG_COUNT_C = 4'(AVERAGE_COUNT);

  localparam logic [2:0] OP_FAST  = 3'd0;
  localparam logic [2:0] OP_SLOW  = 3'd1;
  localparam logic [2:0] OP_UP    = 3'd2;
  localparam logic [2:0] OP_DOWN  = 3'd3;
  localparam logic [2:0] OP_POWER = 3'd4;

  localparam logic [2:0] REG_BAND     = 3'd0;
  localparam logic [2:0] REG_STEP     = 3'd1;
  localparam logic [2:0] REG_MIN      = 3'd2;
  localparam logic [2:0] REG_MAX      = 3'd3;
  localparam logic [2:0] REG_INIT_SP  = 3'd4;
  localparam logic [2:0] REG_SAMPLE   = 3'd5;
  localparam logic [2:0] REG_BLINK    = 3'd6;
  localparam logic [2:0] REG_TIMEOUT  = 3'd7;

  localparam logic [4:0]  BAND_RST    = 5'd5;
  localparam logic [4:0]  STEP_RST    = 5'd5;
  localparam logic [7:0]  MIN_RST     = 8'd35;
  localparam logic [7:0]  MAX_RST     = 8'd75;
  localparam logic [7:0]  INIT_SP_RST = 8'd60;
  localparam logic [15:0] SAMPLE_RST  = 16'd1000;
  localparam logic [15:0] BLINK_RST   = 16'd10000;
  localparam logic [15:0] TIMEOUT_RST = 16'd5000;

  typedef struct packed {
    logic [4:0]  band_half_width;
    logic [4:0]  setpoint_step;
    logic [7:0]  setpoint_min;
    logic [7:0]  setpoint_max;
    logic [15:0] sample_period;
    logic [15:0] blink_period;
    logic [15:0] edit_timeout;
  } cfg_t;

  typedef struct packed {
    logic       heater_on;
    logic       cooler_on;
    logic       heat_led;
    logic       powered;
    logic       editing;
    logic [7:0] shown_value;
  } result_t;

endpackage

/* hdl/dtc_core.sv */
module dtc_core
  import dtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [2:0] op,
  input  logic [7:0] temp,
  output result_t    res
);

  logic        power_r, power_nxt;
  logic        edit_up_r, edit_up_nxt;
  logic        edit_dn_r, edit_dn_nxt;
  logic [7:0]  setpoint_r, setpoint_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [15:0] blink_cnt_r, blink_cnt_nxt;
  logic [15:0] timeout_r, timeout_nxt;
  logic [3:0]  taken_r, taken_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [7:0]  last_r, last_nxt;
  logic        blink_en_r, blink_en_nxt;
  logic        phase_r, phase_nxt;
  logic [2:0]  drive_r, drive_nxt;

  logic [15:0] tick_inc;
  logic [15:0] blink_inc;
  logic [15:0] timeout_inc;
  logic [3:0]  taken_inc;
  logic [SUM_W-1:0] sum_inc;
  logic [SUM_W+RECIP_W-1:0] avg_prod;
  logic [7:0]  avg;
  logic [8:0]  avg_lo, avg_hi;
  logic [8:0]  sp_plus_band;
  logic [8:0]  sp_up;
  logic        edit_now;

  assign tick_inc    = tick_r + 16'd1;
  assign timeout_inc = timeout_r + 16'd1;
  assign taken_inc   = taken_r + 4'd1;
  assign sum_inc     = sum_r + SUM_W'(temp);
  assign avg_prod    = (SUM_W+RECIP_W)'(sum_inc) * (SUM_W+RECIP_W)'(AVG_RECIP);
  assign avg         = avg_prod[RECIP_SHIFT +: 8];
  // Below the band: avg + band < setpoint. Above: avg > setpoint + band.
  assign avg_lo       = {1'b0, avg} + {4'd0, cfg.band_half_width};
  assign sp_plus_band = {1'b0, setpoint_r} + {4'd0, cfg.band_half_width};
  assign avg_hi       = {1'b0, avg};
  assign sp_up        = {1'b0, setpoint_r} + {4'd0, cfg.setpoint_step};

  always_comb begin
    power_nxt     = power_r;
    edit_up_nxt   = edit_up_r;
    edit_dn_nxt   = edit_dn_r;
    setpoint_nxt  = setpoint_r;
    tick_nxt      = tick_r;
    blink_cnt_nxt = blink_cnt_r;
    timeout_nxt   = timeout_r;
    taken_nxt     = taken_r;
    sum_nxt       = sum_r;
    last_nxt      = last_r;
    blink_en_nxt  = blink_en_r;
    phase_nxt     = phase_r;
    drive_nxt     = drive_r;
    blink_inc     = blink_en_r ? blink_cnt_r + 16'd1 : blink_cnt_r;

    case (op)
      OP_FAST: begin
        if (power_r) begin
          tick_nxt      = tick_inc;
          blink_cnt_nxt = blink_inc;
          if (tick_inc == cfg.sample_period) begin
            tick_nxt  = '0;
            last_nxt  = temp;
            taken_nxt = taken_inc;
            sum_nxt   = sum_inc;
            if (taken_inc == AVG_COUNT_C) begin
              taken_nxt = '0;
              sum_nxt   = '0;
              if (avg_lo < {1'b0, setpoint_r}) begin
                drive_nxt    = 3'b001;
                blink_en_nxt = 1'b1;
              end else if (avg_hi > sp_plus_band) begin
                drive_nxt     = 3'b110;
                blink_en_nxt  = 1'b0;
                blink_cnt_nxt = '0;
              end else begin
                drive_nxt     = 3'b000;
                blink_en_nxt  = 1'b0;
                blink_cnt_nxt = '0;
              end
            end
          end
          // The blink match is checked after the decision may have cleared the count.
          if (blink_cnt_nxt == cfg.blink_period) begin
            blink_cnt_nxt = '0;
            phase_nxt     = ~phase_r;
          end
        end
      end
      OP_SLOW: begin
        timeout_nxt = timeout_inc;
        if (timeout_inc == cfg.edit_timeout) begin
          edit_up_nxt = 1'b0;
          edit_dn_nxt = 1'b0;
          timeout_nxt = '0;
        end
      end
      OP_UP: begin
        timeout_nxt = '0;
        if (!edit_up_r && power_r) begin
          edit_up_nxt = 1'b1;
        end else if (edit_up_r && setpoint_r < cfg.setpoint_max) begin
          setpoint_nxt = sp_up[8] ? 8'hFF : sp_up[7:0];
        end
      end
      OP_DOWN: begin
        timeout_nxt = '0;
        if (!edit_dn_r && power_r) begin
          edit_dn_nxt = 1'b1;
        end else if (edit_dn_r && setpoint_r > cfg.setpoint_min) begin
          setpoint_nxt = (setpoint_r >= {3'd0, cfg.setpoint_step}) ?
                         setpoint_r - {3'd0, cfg.setpoint_step} : 8'd0;
        end
      end
      OP_POWER: begin
        if (power_r) begin
          power_nxt     = 1'b0;
          edit_up_nxt   = 1'b0;
          edit_dn_nxt   = 1'b0;
          tick_nxt      = '0;
          blink_cnt_nxt = '0;
          timeout_nxt   = '0;
          taken_nxt     = '0;
          sum_nxt       = '0;
          blink_en_nxt  = 1'b0;
          phase_nxt     = 1'b0;
          drive_nxt     = '0;
        end else begin
          power_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign edit_now        = edit_up_nxt | edit_dn_nxt;
  assign res.heater_on   = drive_nxt[0];
  assign res.cooler_on   = drive_nxt[1];
  assign res.heat_led    = drive_nxt[2] ? 1'b1 : (drive_nxt[0] & phase_nxt);
  assign res.powered     = power_nxt;
  assign res.editing     = edit_now;
  assign res.shown_value = edit_now ? setpoint_nxt : last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r     <= 1'b0;
      edit_up_r   <= 1'b0;
      edit_dn_r   <= 1'b0;
      setpoint_r  <= INIT_SP_RST;
      tick_r      <= '0;
      blink_cnt_r <= '0;
      timeout_r   <= '0;
      taken_r     <= '0;
      sum_r       <= '0;
      last_r      <= '0;
      blink_en_r  <= 1'b0;
      phase_r     <= 1'b0;
      drive_r     <= '0;
    end else if (step) begin
      power_r     <= power_nxt;
      edit_up_r   <= edit_up_nxt;
      edit_dn_r   <= edit_dn_nxt;
      setpoint_r  <= setpoint_nxt;
      tick_r      <= tick_nxt;
      blink_cnt_r <= blink_cnt_nxt;
      timeout_r   <= timeout_nxt;
      taken_r     <= taken_nxt;
      sum_r       <= sum_nxt;
      last_r      <= last_nxt;
      blink_en_r  <= blink_en_nxt;
      phase_r     <= phase_nxt;
      drive_r     <= drive_nxt;
    end
  end

endmodule

/* hdl/deadband_thermostat_controller.sv */
// An accepted item waits in the input register and its result enters the output
// register when the output can advance. Throughput: one item per cycle unless the
// output stalls; each state update is one combinational pass from input to output register.
// Reset (synchronous, rst_n low) restores the register defaults, powers the
// controller off, clears all counters and loads the default setpoint.
module deadband_thermostat_controller
  import dtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_temperature_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_heater_on,
  output logic        out_cooler_on,
  output logic        out_heat_led,
  output logic        out_powered,
  output logic        out_editing,
  output logic [7:0]  out_shown_value
);

  cfg_t       cfg_r;
  logic       in_vld_r;
  logic [2:0] in_op_r;
  logic [7:0] in_temp_r;
  logic       out_vld_r;
  result_t    out_r;
  result_t    res;
  logic       advance;
  logic       step;
  logic       accept;

  assign advance  = !out_vld_r || !out_stall;
  assign step     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;
  assign accept   = in_valid && !in_stall;

  // The initial setpoint register only matters at reset, and reset also
  // restores its default, so its writes are not stored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band_half_width <= BAND_RST;
      cfg_r.setpoint_step   <= STEP_RST;
      cfg_r.setpoint_min    <= MIN_RST;
      cfg_r.setpoint_max    <= MAX_RST;
      cfg_r.sample_period   <= SAMPLE_RST;
      cfg_r.blink_period    <= BLINK_RST;
      cfg_r.edit_timeout    <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BAND:    cfg_r.band_half_width <= cfg_data[4:0];
        REG_STEP:    cfg_r.setpoint_step   <= cfg_data[4:0];
        REG_MIN:     cfg_r.setpoint_min    <= cfg_data[7:0];
        REG_MAX:     cfg_r.setpoint_max    <= cfg_data[7:0];
        REG_INIT_SP: begin
        end
        REG_SAMPLE:  cfg_r.sample_period   <= cfg_data;
        REG_BLINK:   cfg_r.blink_period    <= cfg_data;
        REG_TIMEOUT: cfg_r.edit_timeout    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (step) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_op_r   <= in_operation;
      in_temp_r <= in_temperature_sample;
    end
    if (step) begin
      out_r <= res;
    end
  end

  dtc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .step  (step),
    .op    (in_op_r),
    .temp  (in_temp_r),
    .res   (res)
  );

  assign out_valid       = out_vld_r;
  assign out_heater_on   = out_r.heater_on;
  assign out_cooler_on   = out_r.cooler_on;
  assign out_heat_led    = out_r.heat_led;
  assign out_powered     = out_r.powered;
  assign out_editing     = out_r.editing;
  assign out_shown_value = out_r.shown_value;

endmodule

/* tb/sv/deadband_thermostat_checker.sv */
module deadband_thermostat_checker
  import dtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_temperature_sample,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_heater_on,
  input  logic        out_cooler_on,
  input  logic        out_heat_led,
  input  logic        out_powered,
  input  logic        out_editing,
  input  logic [7:0]  out_shown_value,
  output int          fail_count,
  output int          outstanding,
  output int          results_checked
);

  cfg_t settings;

  logic        power_on;
  logic        edit_up;
  logic        edit_down;
  logic [7:0]  setpoint;
  logic [7:0]  last_temp;
  logic [15:0] tick_cnt;
  logic [15:0] blink_cnt;
  logic [15:0] slow_cnt;
  logic [3:0]  sample_cnt;
  logic [11:0] temp_sum;
  logic        blink_run;
  logic        blink_phase;
  logic        heating;
  logic        cooling;

  result_t expected_readings[$];
  int      mismatches;
  int      compared;

  function automatic void drop_running_state();
    edit_up     = 1'b0;
    edit_down   = 1'b0;
    tick_cnt    = '0;
    blink_cnt   = '0;
    slow_cnt    = '0;
    sample_cnt  = '0;
    temp_sum    = '0;
    blink_run   = 1'b0;
    blink_phase = 1'b0;
    heating     = 1'b0;
    cooling     = 1'b0;
  endfunction

  function automatic result_t step_thermostat(input logic [2:0] op, input logic [7:0] temp);
    result_t r;
    int      avg;
    int      raised;
    case (op)
      OP_FAST: begin
        if (power_on) begin
          tick_cnt = tick_cnt + 16'd1;
          if (blink_run)
            blink_cnt = blink_cnt + 16'd1;
          if (tick_cnt == settings.sample_period) begin
            tick_cnt   = '0;
            last_temp  = temp;
            sample_cnt = sample_cnt + 4'd1;
            temp_sum   = temp_sum + {4'd0, temp};
            if (sample_cnt == AVG_COUNT_C) begin
              avg        = int'(temp_sum) / AVERAGE_COUNT;
              sample_cnt = '0;
              temp_sum   = '0;
              heating    = avg < int'(setpoint) - int'(settings.band_half_width);
              cooling    = !heating && avg > int'(setpoint) + int'(settings.band_half_width);
              blink_run  = heating;
              // Heating keeps its blink count running across decisions.
              if (!heating)
                blink_cnt = '0;
            end
          end
          // The compare runs on every powered tick, even with blinking off.
          if (blink_cnt == settings.blink_period) begin
            blink_cnt   = '0;
            blink_phase = ~blink_phase;
          end
        end
      end
      OP_SLOW: begin
        slow_cnt = slow_cnt + 16'd1;
        if (slow_cnt == settings.edit_timeout) begin
          edit_up   = 1'b0;
          edit_down = 1'b0;
          slow_cnt  = '0;
        end
      end
      OP_UP: begin
        slow_cnt = '0;
        if (!edit_up && power_on) begin
          edit_up = 1'b1;
        end else if (edit_up && setpoint < settings.setpoint_max) begin
          raised   = int'(setpoint) + int'(settings.setpoint_step);
          setpoint = (raised > 255) ? 8'd255 : 8'(raised);
        end
      end
      OP_DOWN: begin
        slow_cnt = '0;
        if (!edit_down && power_on) begin
          edit_down = 1'b1;
        end else if (edit_down && setpoint > settings.setpoint_min) begin
          setpoint = (setpoint >= {3'd0, settings.setpoint_step}) ?
                     setpoint - {3'd0, settings.setpoint_step} : 8'd0;
        end
      end
      OP_POWER: begin
        if (power_on) begin
          power_on = 1'b0;
          drop_running_state();
        end else begin
          power_on = 1'b1;
        end
      end
      default: ;
    endcase
    r.heater_on   = heating;
    r.cooler_on   = cooling;
    r.heat_led    = cooling ? 1'b1 : (heating ? blink_phase : 1'b0);
    r.powered     = power_on;
    r.editing     = edit_up | edit_down;
    r.shown_value = (edit_up | edit_down) ? setpoint : last_temp;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    logic    bad;
    if (!rst_n) begin
      settings.band_half_width = BAND_RST;
      settings.setpoint_step   = STEP_RST;
      settings.setpoint_min    = MIN_RST;
      settings.setpoint_max    = MAX_RST;
      settings.sample_period   = SAMPLE_RST;
      settings.blink_period    = BLINK_RST;
      settings.edit_timeout    = TIMEOUT_RST;
      power_on  = 1'b0;
      setpoint  = INIT_SP_RST;
      last_temp = '0;
      drop_running_state();
      expected_readings.delete();
      mismatches = 0;
      compared   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BAND:    settings.band_half_width = cfg_data[4:0];
          REG_STEP:    settings.setpoint_step   = cfg_data[4:0];
          REG_MIN:     settings.setpoint_min    = cfg_data[7:0];
          REG_MAX:     settings.setpoint_max    = cfg_data[7:0];
          REG_SAMPLE:  settings.sample_period   = cfg_data;
          REG_BLINK:   settings.blink_period    = cfg_data;
          REG_TIMEOUT: settings.edit_timeout    = cfg_data;
          // The initial setpoint only matters at reset, which happens once.
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {out_heater_on, out_cooler_on, out_heat_led, out_powered, out_editing,
               out_shown_value};
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d arrived with no item waiting for it", compared);
        end else begin
          want = expected_readings.pop_front();
          bad  = (got.heater_on !== want.heater_on) || (got.cooler_on !== want.cooler_on) ||
                 (got.heat_led !== want.heat_led) || (got.powered !== want.powered) ||
                 (got.editing !== want.editing) || (got.shown_value !== want.shown_value);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Result %0d: expected heater %0b cooler %0b led %0b powered %0b ",
                        "editing %0b shown %0d, got %0b %0b %0b %0b %0b %0d"},
                       compared, want.heater_on, want.cooler_on, want.heat_led,
                       want.powered, want.editing, want.shown_value, got.heater_on,
                       got.cooler_on, got.heat_led, got.powered, got.editing,
                       got.shown_value);
          end
        end
        compared++;
      end
      if (in_valid && !in_stall)
        expected_readings.push_back(step_thermostat(in_operation, in_temperature_sample));
    end
    fail_count      <= mismatches;
    outstanding     <= expected_readings.size();
    results_checked <= compared;
  end

endmodule

/* tb/sv/deadband_thermostat_controller_test.sv */
module deadband_thermostat_controller_test
  import dtc_pkg::*;
;

  localparam int         CYCLE_LIMIT = 300000;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_operation;
  logic [7:0]  in_temperature_sample;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_heater_on;
  logic        out_cooler_on;
  logic        out_heat_led;
  logic        out_powered;
  logic        out_editing;
  logic [7:0]  out_shown_value;

  int fail_count;
  int outstanding;
  int results_checked;

  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int items_sent  = 0;
  int phases_run  = 0;
  int slow_run    = 0;
  int base_temp   = 60;
  bit power_guess = 1'b0;

  deadband_thermostat_controller uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_operation          (in_operation),
    .in_temperature_sample (in_temperature_sample),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_heater_on         (out_heater_on),
    .out_cooler_on         (out_cooler_on),
    .out_heat_led          (out_heat_led),
    .out_powered           (out_powered),
    .out_editing           (out_editing),
    .out_shown_value       (out_shown_value)
  );

  deadband_thermostat_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_operation          (in_operation),
    .in_temperature_sample (in_temperature_sample),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_heater_on         (out_heater_on),
    .out_cooler_on         (out_cooler_on),
    .out_heat_led          (out_heat_led),
    .out_powered           (out_powered),
    .out_editing           (out_editing),
    .out_shown_value       (out_shown_value),
    .fail_count            (fail_count),
    .outstanding           (outstanding),
    .results_checked       (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic send_item(input logic [2:0] op, input logic [7:0] temp);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_operation          <= op;
    in_temperature_sample <= temp;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    items_sent++;
    if (op == OP_POWER)
      power_guess = !power_guess;
  endtask

  // Holds the sender off until every result has come back out.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic pick_item(output logic [2:0] op, output logic [7:0] temp);
    int roll;
    int t;
    roll = $urandom_range(99);
    if ($urandom_range(29) == 0)
      base_temp = ($urandom_range(3) == 0) ? int'($urandom_range(255)) :
                  int'($urandom_range(100, 20));
    t = base_temp + int'($urandom_range(8)) - 4;
    temp = (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : 8'(t);
    if (slow_run > 0) begin
      op = OP_SLOW;
      slow_run--;
    end else if (!power_guess && roll < 60) begin
      op = OP_POWER;
    end else if (roll < 3) begin
      op = OP_POWER;
    end else if (roll < 8) begin
      op = OP_SPARE_LO + 3'($urandom_range(2));
    end else if (roll < 18) begin
      op = OP_UP;
    end else if (roll < 28) begin
      op = OP_DOWN;
    end else if (roll < 36) begin
      // Runs of slow ticks are what reach the edit timeout.
      op       = OP_SLOW;
      slow_run = $urandom_range(11);
    end else begin
      op = OP_FAST;
    end
  endtask

  task automatic apply_settings(input logic [4:0] band, input logic [4:0] step,
                                input logic [7:0] lo, input logic [7:0] hi,
                                input logic [7:0] init_sp, input logic [15:0] sample,
                                input logic [15:0] blink, input logic [15:0] tmo);
    write_reg(REG_BAND, 16'(band));
    write_reg(REG_STEP, 16'(step));
    write_reg(REG_MIN, 16'(lo));
    write_reg(REG_MAX, 16'(hi));
    write_reg(REG_INIT_SP, 16'(init_sp));
    write_reg(REG_SAMPLE, sample);
    write_reg(REG_BLINK, blink);
    write_reg(REG_TIMEOUT, tmo);
    cfg_we <= 1'b0;
    phases_run++;
  endtask

  task automatic run_phase(input logic [4:0] band, input logic [4:0] step,
                           input logic [7:0] lo, input logic [7:0] hi,
                           input logic [7:0] init_sp, input logic [15:0] sample,
                           input logic [15:0] blink, input logic [15:0] tmo,
                           input int count, input int idle, input int stall);
    logic [2:0] op;
    logic [7:0] temp;
    apply_settings(band, step, lo, hi, init_sp, sample, blink, tmo);
    idle_pct = idle;
    stall_pct <= stall;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(199) == 0)
        wait_for_drain();
      pick_item(op, temp);
      send_item(op, temp);
    end
    wait_for_drain();
  endtask

  initial begin
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_BAND;
    cfg_data              <= '0;
    in_valid              <= 1'b0;
    in_operation          <= OP_FAST;
    in_temperature_sample <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: one sample per fast tick, quick blink and edit timeout.
    apply_settings(BAND_RST, STEP_RST, MIN_RST, MAX_RST, INIT_SP_RST, 16'd1, 16'd2, 16'd2);
    send_item(OP_SPARE_LO, 8'hA5);
    send_item(OP_SPARE_HI, 8'h5A);
    send_item(OP_FAST, 8'd255);
    send_item(OP_UP, 8'd0);
    send_item(OP_DOWN, 8'd0);
    send_item(OP_POWER, 8'd0);
    send_item(OP_UP, 8'd0);
    send_item(OP_UP, 8'd0);
    send_item(OP_DOWN, 8'd0);
    send_item(OP_DOWN, 8'd0);
    send_item(OP_SLOW, 8'd0);
    send_item(OP_SLOW, 8'd0);
    // Ten samples averaging well under the band start heating and blinking.
    repeat (9) send_item(OP_FAST, 8'd0);
    send_item(OP_FAST, 8'd255);
    send_item(OP_FAST, 8'd0);
    send_item(OP_FAST, 8'd0);
    send_item(OP_POWER, 8'd0);
    send_item(OP_POWER, 8'd0);
    wait_for_drain();

    run_phase(5'd5, 5'd5, 8'd35, 8'd75, 8'd60, 16'd1, 16'd2, 16'd4, 250, 0, 0);
    run_phase(5'd0, 5'd1, 8'd0, 8'd255, 8'd0, 16'd2, 16'd1, 16'd1, 250, 49, 0);
    run_phase(5'd31, 5'd31, 8'd255, 8'd0, 8'd255, 16'd1, 16'd3, 16'd6, 250, 0, 49);
    run_phase(5'd3, 5'd31, 8'd10, 8'd240, 8'd128, 16'd3, 16'hFFFF, 16'hFFFF, 200, 37, 37);
    // Zero sample and timeout periods match once the 16-bit counters wrap.
    run_phase(5'd10, 5'd7, 8'd0, 8'd255, 8'd60, 16'd0, 16'd0, 16'd0, 100, 37, 37);
    run_phase(5'd2, 5'd13, 8'd20, 8'd200, 8'd90, 16'hFFFF, 16'd5, 16'd10, 100, 49, 49);
    run_phase(5'd4, 5'd3, 8'd40, 8'd90, 8'd70, 16'd1, 16'd4, 16'd8, 400, 0, 0);

    stall_pct <= 0;
    wait_for_drain();
    repeat (10) @(posedge clk);

    $display("Drove %0d items through %0d register settings, zero and full-scale periods too.",
             items_sent, phases_run);
    $display("Compared %0d results field by field.", results_checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/dtc_pkg.sv
hdl/dtc_core.sv
hdl/deadband_thermostat_controller.sv
tb/sv/deadband_thermostat_checker.sv
tb/sv/deadband_thermostat_controller_test.sv
